[design/igl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package igl_pkg;

    localparam int DEF_MAX_ROW     = 1024;
    localparam int DEF_SAMPLE_BITS = 18;
    localparam int DEF_NUM_FIELDS  = 1;

    localparam int OUT_BITS       = 24;
    localparam int POS_BITS       = 10;
    localparam int WEIGHT_BITS    = 18;
    localparam int ROW_LEN_BITS   = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;
    localparam int FRAC_BITS      = 16;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    localparam logic [ROW_LEN_BITS-1:0] RST_ROW_LENGTH  = ROW_LEN_BITS'(64);
    localparam logic [WEIGHT_BITS-1:0]  RST_GRAD_NEAR   = WEIGHT_BITS'(21845);
    localparam logic [WEIGHT_BITS-1:0]  RST_GRAD_DIAG   = WEIGHT_BITS'(5461);
    localparam logic [WEIGHT_BITS-1:0]  RST_LAP_CENTER  = WEIGHT_BITS'(218453);
    localparam logic [WEIGHT_BITS-1:0]  RST_LAP_NEAR    = WEIGHT_BITS'(43691);
    localparam logic [WEIGHT_BITS-1:0]  RST_LAP_DIAG    = WEIGHT_BITS'(10923);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW_LENGTH  = 3'd0,
        REG_GRAD_NEAR   = 3'd1,
        REG_GRAD_DIAG   = 3'd2,
        REG_LAP_CENTER  = 3'd3,
        REG_LAP_NEAR    = 3'd4,
        REG_LAP_DIAG    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] grad_near;
        logic [WEIGHT_BITS-1:0] grad_diag;
        logic [WEIGHT_BITS-1:0] lap_center;
        logic [WEIGHT_BITS-1:0] lap_near;
        logic [WEIGHT_BITS-1:0] lap_diag;
    } igl_weights_t;

    typedef struct packed {
        logic                emit;
        logic                last;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } igl_tag_t;

endpackage

`default_nettype wire

[design/igl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module igl_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/igl_calc.sv]
`timescale 1ns / 1ps
`default_nettype none

module igl_calc #(
    parameter int SAMPLE_BITS = 18
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire igl_pkg::igl_tag_t                   in_tag,
    input  wire igl_pkg::igl_weights_t               weights,
    input  wire logic signed [SAMPLE_BITS+1:0]       gx_diag,
    input  wire logic signed [SAMPLE_BITS+1:0]       gx_near,
    input  wire logic signed [SAMPLE_BITS+1:0]       gy_diag,
    input  wire logic signed [SAMPLE_BITS+1:0]       gy_near,
    input  wire logic signed [SAMPLE_BITS+1:0]       lp_near,
    input  wire logic signed [SAMPLE_BITS+1:0]       lp_diag,
    input  wire logic signed [SAMPLE_BITS+1:0]       lp_center,
    output logic                                     out_valid,
    output igl_pkg::igl_tag_t                        out_tag,
    output logic signed [igl_pkg::OUT_BITS-1:0]      grad_x,
    output logic signed [igl_pkg::OUT_BITS-1:0]      grad_y,
    output logic signed [igl_pkg::OUT_BITS-1:0]      laplacian
);

    import igl_pkg::*;

    localparam int SW   = SAMPLE_BITS + 2;
    localparam int WW   = WEIGHT_BITS + 1;
    localparam int PW   = SW + WW;
    localparam int SUMW = (PW + 2 > OUT_BITS + FRAC_BITS + 1) ? PW + 2
                                                               : OUT_BITS + FRAC_BITS + 1;
    localparam int QW   = SUMW - FRAC_BITS;

    localparam logic signed [QW-1:0] QMAX = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] QMIN = QW'(OUT_MIN);

    function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [SUMW-1:0] s);
        logic signed [SUMW-1:0] v;
        logic signed [QW-1:0]   q;
        v = s + SUMW'(32768);
        q = v[SUMW-1:FRAC_BITS];
        if (q > QMAX)
        begin
            q = QMAX;
        end
        else if (q < QMIN)
        begin
            q = QMIN;
        end
        return OUT_BITS'(q);
    endfunction

    logic signed [WW-1:0] wgn;
    logic signed [WW-1:0] wgd;
    logic signed [WW-1:0] wlc;
    logic signed [WW-1:0] wln;
    logic signed [WW-1:0] wld;

    assign wgn = $signed({1'b0, weights.grad_near});
    assign wgd = $signed({1'b0, weights.grad_diag});
    assign wlc = $signed({1'b0, weights.lap_center});
    assign wln = $signed({1'b0, weights.lap_near});
    assign wld = $signed({1'b0, weights.lap_diag});

    // product stage
    logic              p3_valid_reg;
    igl_tag_t          p3_tag_reg;
    logic signed [PW-1:0] gxd_prod_reg;
    logic signed [PW-1:0] gxn_prod_reg;
    logic signed [PW-1:0] gyd_prod_reg;
    logic signed [PW-1:0] gyn_prod_reg;
    logic signed [PW-1:0] lpn_prod_reg;
    logic signed [PW-1:0] lpd_prod_reg;
    logic signed [PW-1:0] lpc_prod_reg;

    // result stage
    logic                        out_valid_reg;
    igl_tag_t                    out_tag_reg;
    logic signed [OUT_BITS-1:0]  grad_x_reg;
    logic signed [OUT_BITS-1:0]  grad_y_reg;
    logic signed [OUT_BITS-1:0]  laplacian_reg;

    logic signed [SUMW-1:0] gx_sum;
    logic signed [SUMW-1:0] gy_sum;
    logic signed [SUMW-1:0] lp_sum;

    always_comb
    begin
        gx_sum = SUMW'(gxd_prod_reg) + SUMW'(gxn_prod_reg);
        gy_sum = SUMW'(gyd_prod_reg) + SUMW'(gyn_prod_reg);
        lp_sum = SUMW'(lpn_prod_reg) + SUMW'(lpd_prod_reg) - SUMW'(lpc_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_valid_reg  <= in_valid;
            out_valid_reg <= p3_valid_reg && p3_tag_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_tag_reg    <= in_tag;
            gxd_prod_reg  <= PW'(gx_diag) * PW'(wgd);
            gxn_prod_reg  <= PW'(gx_near) * PW'(wgn);
            gyd_prod_reg  <= PW'(gy_diag) * PW'(wgd);
            gyn_prod_reg  <= PW'(gy_near) * PW'(wgn);
            lpn_prod_reg  <= PW'(lp_near) * PW'(wln);
            lpd_prod_reg  <= PW'(lp_diag) * PW'(wld);
            lpc_prod_reg  <= PW'(lp_center) * PW'(wlc);
            out_tag_reg   <= p3_tag_reg;
            grad_x_reg    <= round_sat(gx_sum);
            grad_y_reg    <= round_sat(gy_sum);
            laplacian_reg <= round_sat(lp_sum);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign grad_x    = grad_x_reg;
    assign grad_y    = grad_y_reg;
    assign laplacian = laplacian_reg;

endmodule

`default_nettype wire

[design/isotropic_9pt_gradient_laplacian.sv]
`timescale 1ns / 1ps
`default_nettype none

// Nine-point gradient and Laplacian over a raster-ordered, halo-padded grid.
// One sample is taken every cycle while the result register is free or being
// drained; in_stall only follows a stalled, full result register. The sample
// that completes a 3x3 neighborhood passes the line-store read stage, the
// window and pairwise-sum stage, the weight-multiply stage and a final stage
// of add, round half up and saturation to a signed 24-bit integer (Q24.0).
// The two line stores are single-write, single-read memories with a
// read-modify-write per sample; a sample that reads the entry written in the
// same cycle gets the new value by forwarding. There is no clearing pass
// after reset: results only use line-store entries written in the current
// frame. Samples of the first two rows and columns give no result.
// Registers are to be written only while the block is idle.
module isotropic_9pt_gradient_laplacian #(
    parameter int MAX_ROW     = igl_pkg::DEF_MAX_ROW,
    parameter int SAMPLE_BITS = igl_pkg::DEF_SAMPLE_BITS,
    parameter int NUM_FIELDS  = igl_pkg::DEF_NUM_FIELDS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [igl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [igl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic                                 frame_end,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [igl_pkg::OUT_BITS-1:0]       grad_x,
    output logic signed [igl_pkg::OUT_BITS-1:0]       grad_y,
    output logic signed [igl_pkg::OUT_BITS-1:0]       laplacian,
    output logic [igl_pkg::POS_BITS-1:0]              site_row,
    output logic [igl_pkg::POS_BITS-1:0]              site_col,
    output logic                                      last
);

    import igl_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = SAMPLE_BITS + 2;
    localparam int DEPTH = MAX_ROW * NUM_FIELDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ROW);
    localparam int FW    = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int LW    = ($clog2(MAX_ROW + 1) > ROW_LEN_BITS) ? $clog2(MAX_ROW + 1)
                                                                 : ROW_LEN_BITS;
    localparam int CXW   = (CW > POS_BITS) ? CW : POS_BITS;

    // configuration
    logic [ROW_LEN_BITS-1:0] row_length_reg;
    igl_weights_t            weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg         <= RST_ROW_LENGTH;
            weights_reg.grad_near  <= RST_GRAD_NEAR;
            weights_reg.grad_diag  <= RST_GRAD_DIAG;
            weights_reg.lap_center <= RST_LAP_CENTER;
            weights_reg.lap_near   <= RST_LAP_NEAR;
            weights_reg.lap_diag   <= RST_LAP_DIAG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_LENGTH: row_length_reg         <= cfg_data[ROW_LEN_BITS-1:0];
                REG_GRAD_NEAR:  weights_reg.grad_near  <= cfg_data[WEIGHT_BITS-1:0];
                REG_GRAD_DIAG:  weights_reg.grad_diag  <= cfg_data[WEIGHT_BITS-1:0];
                REG_LAP_CENTER: weights_reg.lap_center <= cfg_data[WEIGHT_BITS-1:0];
                REG_LAP_NEAR:   weights_reg.lap_near   <= cfg_data[WEIGHT_BITS-1:0];
                REG_LAP_DIAG:   weights_reg.lap_diag   <= cfg_data[WEIGHT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline advance
    logic calc_out_valid;
    logic adv;
    logic acc;

    assign adv      = !calc_out_valid || !out_stall;
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // raster position
    logic [POS_BITS-1:0] row_reg;
    logic [CW-1:0]       col_reg;
    logic [FW-1:0]       fld_reg;
    logic [POS_BITS-1:0] row_next;
    logic [CW-1:0]       col_next;
    logic [FW-1:0]       fld_next;
    logic [LW-1:0]       row_len_ext;
    logic [LW-1:0]       eff_len;
    logic [LW-1:0]       col_plus;
    logic                fld_last;
    logic [AW-1:0]       in_addr;
    igl_tag_t            in_tag;

    always_comb
    begin
        row_len_ext = LW'(row_length_reg);
        if (row_len_ext < LW'(3))
        begin
            eff_len = LW'(3);
        end
        else if (row_len_ext > LW'(MAX_ROW))
        begin
            eff_len = LW'(MAX_ROW);
        end
        else
        begin
            eff_len = row_len_ext;
        end
        col_plus = LW'(col_reg) + LW'(1);
        fld_last = (fld_reg == FW'(NUM_FIELDS - 1));
        in_addr  = AW'(col_reg) * AW'(NUM_FIELDS) + AW'(fld_reg);

        in_tag.emit = (row_reg >= POS_BITS'(2)) && (col_reg >= CW'(2));
        in_tag.last = frame_end;
        in_tag.row  = row_reg - POS_BITS'(1);
        in_tag.col  = POS_BITS'(CXW'(col_reg) - CXW'(1));

        row_next = row_reg;
        col_next = col_reg;
        fld_next = fld_reg;
        priority if (frame_end)
        begin
            row_next = '0;
            col_next = '0;
            fld_next = '0;
        end
        else if (!fld_last)
        begin
            fld_next = fld_reg + FW'(1);
        end
        else if (col_plus >= eff_len)
        begin
            fld_next = '0;
            col_next = '0;
            row_next = row_reg + POS_BITS'(1);
        end
        else
        begin
            fld_next = '0;
            col_next = CW'(col_plus);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            fld_reg <= '0;
        end
        else if (acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            fld_reg <= fld_next;
        end
    end

    // read stage
    logic                 p1_valid_reg;
    logic signed [SB-1:0] p1_sample_reg;
    logic [AW-1:0]        p1_addr_reg;
    logic [FW-1:0]        p1_fld_reg;
    igl_tag_t             p1_tag_reg;

    logic                 fwd_sel_reg;
    logic signed [SB-1:0] fwd_a_reg;
    logic signed [SB-1:0] fwd_b_reg;
    logic                 fwd_sel_next;

    logic [SB-1:0]        ram_a_q;
    logic [SB-1:0]        ram_b_q;
    logic signed [SB-1:0] a_rd;
    logic signed [SB-1:0] b_rd;
    logic                 ram_we;

    assign a_rd         = fwd_sel_reg ? fwd_a_reg : $signed(ram_a_q);
    assign b_rd         = fwd_sel_reg ? fwd_b_reg : $signed(ram_b_q);
    assign ram_we       = p1_valid_reg && adv;
    assign fwd_sel_next = acc && p1_valid_reg && (in_addr == p1_addr_reg);

    igl_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_line_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_addr_reg),
        .wdata (p1_sample_reg),
        .re    (adv),
        .raddr (in_addr),
        .rdata (ram_a_q)
    );

    igl_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_line_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_addr_reg),
        .wdata (a_rd),
        .re    (adv),
        .raddr (in_addr),
        .rdata (ram_b_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= acc;
            fwd_sel_reg  <= fwd_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sample_reg <= sample;
            p1_addr_reg   <= in_addr;
            p1_fld_reg    <= fld_reg;
            p1_tag_reg    <= in_tag;
            fwd_a_reg     <= p1_sample_reg;
            fwd_b_reg     <= a_rd;
        end
    end

    // window: columns c-2 (0..2) and c-1 (3..5), rows r-2..r
    logic [SB-1:0] win_reg [NUM_FIELDS][6];
    logic [SB-1:0] win_cur [6];

    assign win_cur = win_reg[p1_fld_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    win_reg[i][k] <= '0;
                end
            end
        end
        else if (ram_we)
        begin
            win_reg[p1_fld_reg][0] <= win_cur[3];
            win_reg[p1_fld_reg][1] <= win_cur[4];
            win_reg[p1_fld_reg][2] <= win_cur[5];
            win_reg[p1_fld_reg][3] <= b_rd;
            win_reg[p1_fld_reg][4] <= a_rd;
            win_reg[p1_fld_reg][5] <= p1_sample_reg;
        end
    end

    // neighborhood sums
    logic signed [SB-1:0] f00, f01, f02, f10, f11, f12, f20, f21, f22;
    logic signed [SW-1:0] gx_diag, gx_near, gy_diag, gy_near;
    logic signed [SW-1:0] lp_near, lp_diag, lp_center;

    always_comb
    begin
        f00 = $signed(win_cur[0]);
        f10 = $signed(win_cur[1]);
        f20 = $signed(win_cur[2]);
        f01 = $signed(win_cur[3]);
        f11 = $signed(win_cur[4]);
        f21 = $signed(win_cur[5]);
        f02 = b_rd;
        f12 = a_rd;
        f22 = p1_sample_reg;

        gx_diag   = SW'(f20) - SW'(f00) + SW'(f22) - SW'(f02);
        gx_near   = SW'(f21) - SW'(f01);
        gy_diag   = SW'(f02) - SW'(f00) + SW'(f22) - SW'(f20);
        gy_near   = SW'(f12) - SW'(f10);
        lp_near   = SW'(f01) + SW'(f21) + SW'(f10) + SW'(f12);
        lp_diag   = SW'(f00) + SW'(f02) + SW'(f20) + SW'(f22);
        lp_center = SW'(f11);
    end

    logic                 p2_valid_reg;
    igl_tag_t             p2_tag_reg;
    logic signed [SW-1:0] p2_gx_diag_reg, p2_gx_near_reg;
    logic signed [SW-1:0] p2_gy_diag_reg, p2_gy_near_reg;
    logic signed [SW-1:0] p2_lp_near_reg, p2_lp_diag_reg, p2_lp_center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_tag_reg       <= p1_tag_reg;
            p2_gx_diag_reg   <= gx_diag;
            p2_gx_near_reg   <= gx_near;
            p2_gy_diag_reg   <= gy_diag;
            p2_gy_near_reg   <= gy_near;
            p2_lp_near_reg   <= lp_near;
            p2_lp_diag_reg   <= lp_diag;
            p2_lp_center_reg <= lp_center;
        end
    end

    igl_tag_t out_tag;

    igl_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_valid_reg),
        .in_tag    (p2_tag_reg),
        .weights   (weights_reg),
        .gx_diag   (p2_gx_diag_reg),
        .gx_near   (p2_gx_near_reg),
        .gy_diag   (p2_gy_diag_reg),
        .gy_near   (p2_gy_near_reg),
        .lp_near   (p2_lp_near_reg),
        .lp_diag   (p2_lp_diag_reg),
        .lp_center (p2_lp_center_reg),
        .out_valid (calc_out_valid),
        .out_tag   (out_tag),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .laplacian (laplacian)
    );

    assign out_valid = calc_out_valid;
    assign site_row  = out_tag.row;
    assign site_col  = out_tag.col;
    assign last      = out_tag.last;

    a_stall_only_on_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled without a stalled result");

    a_forward_needs_prior_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        fwd_sel_reg |-> $past(p1_valid_reg)
    ) else $error("line-store forward selected without a preceding write");

    a_frame_end_clears_position: assert property (
        @(posedge clk) disable iff (!rst_n)
        (acc && frame_end) |=> (row_reg == '0 && col_reg == '0 && fld_reg == '0)
    ) else $error("position not cleared after frame end");

endmodule

`default_nettype wire

[tb/isotropic_9pt_gradient_laplacian_tb.sv]
`timescale 1ns / 1ps

module isotropic_9pt_gradient_laplacian_tb;

    import igl_pkg::*;

    localparam int SB          = DEF_SAMPLE_BITS;
    localparam int MAX_ROW     = DEF_MAX_ROW;
    localparam int DRAIN_WAIT  = 12;
    localparam int FINAL_WAIT  = 20;
    localparam int QUIET_LIMIT = 5000;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct {
        logic signed [OUT_BITS-1:0] grad_x;
        logic signed [OUT_BITS-1:0] grad_y;
        logic signed [OUT_BITS-1:0] laplacian;
        logic [POS_BITS-1:0]        row;
        logic [POS_BITS-1:0]        col;
        logic                       last;
    } site_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    cfg_reg_t                   cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SB-1:0]       sample;
    logic                       frame_end;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_BITS-1:0] grad_x;
    logic signed [OUT_BITS-1:0] grad_y;
    logic signed [OUT_BITS-1:0] laplacian;
    logic [POS_BITS-1:0]        site_row;
    logic [POS_BITS-1:0]        site_col;
    logic                       last;

    // predictor state
    logic signed [SB-1:0]      row_above [MAX_ROW];
    logic signed [SB-1:0]      row_two_above [MAX_ROW];
    logic signed [SB-1:0]      win [6];
    int unsigned               row_pos;
    int unsigned               col_pos;
    logic [ROW_LEN_BITS-1:0]   row_len_reg;
    igl_weights_t              weights;

    site_result_t pending_sites [$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;

    always #4 clk = ~clk;

    isotropic_9pt_gradient_laplacian DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .laplacian (laplacian),
        .site_row  (site_row),
        .site_col  (site_col),
        .last      (last)
    );

    function automatic int unsigned eff_row_length();
        if (row_len_reg < 3)
            return 3;
        if (row_len_reg > MAX_ROW)
            return MAX_ROW;
        return 32'(row_len_reg);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] q16_round_sat(input longint acc);
        longint q;
        q = (acc + 32768) >>> FRAC_BITS;
        if (q > OUT_MAX)
            q = OUT_MAX;
        else if (q < OUT_MIN)
            q = OUT_MIN;
        return q[OUT_BITS-1:0];
    endfunction

    task automatic predict_site(input logic signed [SB-1:0] value, input logic fend);
        longint       f [3][3];
        longint       wn, wd, lc, ln, ld;
        int unsigned  len;
        site_result_t r;
        len = eff_row_length();
        for (int k = 0; k < 3; k++)
        begin
            f[k][0] = longint'(win[k]);
            f[k][1] = longint'(win[3 + k]);
        end
        f[0][2] = longint'(row_two_above[col_pos]);
        f[1][2] = longint'(row_above[col_pos]);
        f[2][2] = longint'(value);
        if (row_pos >= 2 && col_pos >= 2)
        begin
            wn = longint'(weights.grad_near);
            wd = longint'(weights.grad_diag);
            lc = longint'(weights.lap_center);
            ln = longint'(weights.lap_near);
            ld = longint'(weights.lap_diag);
            r.grad_x = q16_round_sat(wd * (f[2][0] - f[0][0]) + wn * (f[2][1] - f[0][1])
                                     + wd * (f[2][2] - f[0][2]));
            r.grad_y = q16_round_sat(wd * (f[0][2] - f[0][0]) + wn * (f[1][2] - f[1][0])
                                     + wd * (f[2][2] - f[2][0]));
            r.laplacian = q16_round_sat(ln * (f[0][1] + f[2][1] + f[1][0] + f[1][2])
                                        + ld * (f[0][0] + f[0][2] + f[2][0] + f[2][2])
                                        - lc * f[1][1]);
            r.row = POS_BITS'(row_pos - 1);
            r.col = POS_BITS'(col_pos - 1);
            r.last = fend;
            pending_sites.push_back(r);
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k] = win[3 + k];
            win[3 + k] = f[k][2][SB-1:0];
        end
        row_two_above[col_pos] = row_above[col_pos];
        row_above[col_pos] = value;
        if (fend)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        else if (col_pos + 1 >= len)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) % 1024;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic reset_predictor();
        for (int i = 0; i < MAX_ROW; i++)
        begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        for (int k = 0; k < 6; k++)
            win[k] = '0;
        row_pos = 0;
        col_pos = 0;
        row_len_reg = RST_ROW_LENGTH;
        weights.grad_near = RST_GRAD_NEAR;
        weights.grad_diag = RST_GRAD_DIAG;
        weights.lap_center = RST_LAP_CENTER;
        weights.lap_near = RST_LAP_NEAR;
        weights.lap_diag = RST_LAP_DIAG;
    endtask

    task automatic report_mismatch(input string what, input site_result_t at,
                                   input longint got, input longint want);
        error_count++;
        if (error_count <= 100)
            $display("%0t site (%0d,%0d) %s: got %0d, expected %0d",
                     $time, at.row, at.col, what, got, want);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(negedge clk)
    begin : check_sites
        site_result_t want;
        site_result_t seen;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            seen.row = site_row;
            seen.col = site_col;
            if (pending_sites.size() == 0)
            begin
                report_mismatch("unexpected result", seen, 1, 0);
            end
            else
            begin
                want = pending_sites.pop_front();
                if (grad_x !== want.grad_x)
                    report_mismatch("grad_x", want, grad_x, want.grad_x);
                if (grad_y !== want.grad_y)
                    report_mismatch("grad_y", want, grad_y, want.grad_y);
                if (laplacian !== want.laplacian)
                    report_mismatch("laplacian", want, laplacian, want.laplacian);
                if (site_row !== want.row)
                    report_mismatch("site_row", want, site_row, want.row);
                if (site_col !== want.col)
                    report_mismatch("site_col", want, site_col, want.col);
                if (last !== want.last)
                    report_mismatch("last", want, last, want.last);
            end
        end
    end

    always @(negedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SB-1:0] value, input logic fend);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        frame_end <= fend;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            if (taken)
                predict_site(value, fend);
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_sites.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ROW_LENGTH: row_len_reg = value[ROW_LEN_BITS-1:0];
            REG_GRAD_NEAR:  weights.grad_near = value;
            REG_GRAD_DIAG:  weights.grad_diag = value;
            REG_LAP_CENTER: weights.lap_center = value;
            REG_LAP_NEAR:   weights.lap_near = value;
            REG_LAP_DIAG:   weights.lap_diag = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input int len_raw, input igl_weights_t w);
        write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(len_raw));
        write_reg(REG_GRAD_NEAR, w.grad_near);
        write_reg(REG_GRAD_DIAG, w.grad_diag);
        write_reg(REG_LAP_CENTER, w.lap_center);
        write_reg(REG_LAP_NEAR, w.lap_near);
        write_reg(REG_LAP_DIAG, w.lap_diag);
    endtask

    function automatic logic signed [SB-1:0] random_sample();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            2: return SB'(int'($urandom_range(0, 6)) - 3);
            default: return SB'($urandom());
        endcase
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return WEIGHT_BITS'($urandom());
        endcase
    endfunction

    // random samples, frame end on the last one, optional drain partway
    task automatic send_random_frame(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_idle();
            send_sample(random_sample(), i == count - 1);
        end
    endtask

    task automatic test_reset_config();
        send_random_frame(64 * 3 + 5, -1);
    endtask

    task automatic test_edge_values();
        logic signed [SB-1:0] corner [9];
        logic signed [SB-1:0] ties [12];
        igl_weights_t         w;
        corner = '{S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX};
        ties = '{SB'(0), SB'(-1), SB'(0), SB'(0), S_MAX, SB'(1),
                 SB'(0), SB'(0), SB'(0), SB'(0), SB'(1), SB'(0)};
        wait_idle();
        w = '1;
        load_settings(0, w);
        for (int i = 0; i < 9; i++)
            send_sample(corner[i], i == 8);
        wait_idle();
        // half-way rounding in both directions
        w.grad_near = WEIGHT_BITS'(32768);
        w.grad_diag = '0;
        w.lap_center = WEIGHT_BITS'(1);
        w.lap_near = '0;
        w.lap_diag = '0;
        load_settings(1, w);
        for (int i = 0; i < 12; i++)
            send_sample(ties[i], i == 11);
        // frame end that completes no site
        send_random_frame(4, -1);
    endtask

    task automatic test_row_shrink();
        igl_weights_t w;
        wait_idle();
        w = '0;
        w.grad_near = RST_GRAD_NEAR;
        w.grad_diag = RST_GRAD_DIAG;
        w.lap_center = RST_LAP_CENTER;
        w.lap_near = RST_LAP_NEAR;
        w.lap_diag = RST_LAP_DIAG;
        load_settings(8, w);
        for (int i = 0; i < 22; i++)
            send_sample(random_sample(), 1'b0);
        wait_idle();
        write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(4));
        send_sample(random_sample(), 1'b0);
        send_random_frame(4, -1);
    endtask

    task automatic test_random_frames(input int budget);
        int           sent;
        int           len_raw;
        int           rows;
        int           total;
        int           pause_at;
        igl_weights_t w;
        sent = 0;
        while (sent < budget)
        begin
            wait_idle();
            case ($urandom_range(9))
                0: len_raw = $urandom_range(0, 2);
                1, 2: len_raw = $urandom_range(13, 40);
                default: len_raw = $urandom_range(3, 12);
            endcase
            w.grad_near = random_weight();
            w.grad_diag = random_weight();
            w.lap_center = random_weight();
            w.lap_near = random_weight();
            w.lap_diag = random_weight();
            load_settings(len_raw, w);
            rows = $urandom_range(3, 8);
            total = rows * eff_row_length();
            if ($urandom_range(99) < 15)
                total = $urandom_range(1, total);
            pause_at = -1;
            if ($urandom_range(99) < 15 && total > 1)
                pause_at = $urandom_range(1, total - 1);
            send_random_frame(total, pause_at);
            sent += total;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_ROW_LENGTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sample <= '0;
        frame_end <= 1'b0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_stall_pct = 86;
        test_reset_config();
        test_edge_values();
        test_random_frames(500);

        send_idle_pct = 86;
        recv_stall_pct = 28;
        test_row_shrink();
        test_random_frames(500);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_frames(500);

        in_valid <= 1'b0;
        while (pending_sites.size() != 0)
            @(posedge clk);
        repeat (FINAL_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
